// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ===== rtl/imc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imc_pkg
// Types and constants of the iron mode controller.
// ----------------------------------------------------------------------------
package imc_pkg;

    localparam int TIME_BITS = 32;
    localparam int NOW_W     = 32;
    localparam int LIMIT_W   = 24;
    localparam int CMP_W     = (TIME_BITS > LIMIT_W) ? TIME_BITS : LIMIT_W;
    localparam int SUM_W     = 17;
    localparam int PADDR_W   = 5;

    localparam int unsigned SAVE_DELAY_MS = 30000;
    localparam int unsigned MS_PER_MINUTE = 60000;

    localparam logic [1:0]  POWER_ON_RST   = 2'd0;
    localparam logic [7:0]  SLEEP_MIN_RST  = 8'd30;
    localparam logic [7:0]  STANDBY_MIN_RST = 8'd5;
    localparam logic [6:0]  STEP_RST       = 7'd10;
    localparam logic [15:0] HOLD_MS_RST    = 16'd1000;
    localparam logic [8:0]  TEMP_MIN_RST   = 9'd100;
    localparam logic [8:0]  TEMP_MAX_RST   = 9'd450;
    localparam logic [8:0]  INIT_SP_RST    = 9'd320;

    typedef enum logic [2:0] {
        MODE_INIT    = 3'd0,
        MODE_RUN     = 3'd1,
        MODE_SETPT   = 3'd2,
        MODE_BOOST   = 3'd3,
        MODE_STANDBY = 3'd4,
        MODE_SLEEP   = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        PON_RUN     = 2'd0,
        PON_STANDBY = 2'd1,
        PON_SLEEP   = 2'd2,
        PON_ALT_RUN = 2'd3
    } pon_mode_t;

    typedef enum logic [2:0] {
        REG_POWER_ON_MODE    = 3'd0,
        REG_SLEEP_MINUTES    = 3'd1,
        REG_STANDBY_MINUTES  = 3'd2,
        REG_TEMP_STEP_SIZE   = 3'd3,
        REG_SETPOINT_HOLD_MS = 3'd4,
        REG_TEMP_MIN         = 3'd5,
        REG_TEMP_MAX         = 3'd6,
        REG_INITIAL_SETPOINT = 3'd7
    } reg_idx_t;

endpackage

// ===== rtl/iron_mode_controller_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iron_mode_controller_unit
// Mode, setpoint and timeout control of a heated tool, one poll per request.
// ----------------------------------------------------------------------------
// Each poll request passes an input register and a result register, and one
// poll is taken in every cycle while the output side keeps up. The mode,
// setpoint and activity times are updated in the single cycle in which a poll
// moves from the input register to the result register. The idle limits in
// milliseconds are computed when the minute registers are written, so the
// poll path holds only compares, one 8 x 7 bit multiply and the setpoint
// clamp.
`include "assert_macros.svh"

module iron_mode_controller_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    // Poll request channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [31:0]                  now_ms,
    input  logic signed [7:0]            encoder_delta,
    input  logic                         button_held,
    input  logic                         short_click,
    input  logic                         long_click,
    input  logic                         motion_seen,
    // Result channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [2:0]                   mode,
    output logic [8:0]                   setpoint_value,
    output logic                         save_pulse,
    output logic                         menu_request,
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [imc_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    import imc_pkg::*;

    // Configuration registers
    logic [1:0]         power_on_mode_reg;
    logic [7:0]         sleep_minutes_reg;
    logic [7:0]         standby_minutes_reg;
    logic [6:0]         temp_step_size_reg;
    logic [15:0]        setpoint_hold_ms_reg;
    logic [8:0]         temp_min_reg;
    logic [8:0]         temp_max_reg;
    logic [8:0]         initial_setpoint_reg;
    logic [LIMIT_W-1:0] sleep_limit_reg;
    logic [LIMIT_W-1:0] standby_limit_reg;

    reg_idx_t           reg_idx;
    logic               cfg_write;

    // Input stage
    logic                  s1_valid_reg;
    logic [TIME_BITS-1:0]  now_reg;
    logic signed [7:0]     delta_reg;
    logic                  held_reg;
    logic                  click_reg;
    logic                  long_reg;
    logic                  moved_reg;

    // Controller state
    mode_t                 mode_reg, mode_next;
    logic [8:0]            setpoint_reg, setpoint_next;
    logic [TIME_BITS-1:0]  active_time_reg, active_time_next;
    logic [TIME_BITS-1:0]  knob_time_reg, knob_time_next;
    logic                  change_pending_reg, change_pending_next;
    logic [TIME_BITS-1:0]  change_time_reg, change_time_next;

    // Result stage
    logic                  out_valid_reg;
    logic [2:0]            mode_out_reg;
    logic [8:0]            setpoint_out_reg;
    logic                  save_reg, save_next;
    logic                  menu_reg, menu_next;

    logic                  advance;

    // Poll decode
    logic                  delta_nz;
    logic [TIME_BITS-1:0]  idle_ms, knob_ms, change_ms;
    logic                  sleep_due, standby_due, save_due, hold_done;
    logic                  adjust;
    logic signed [15:0]    step_product;
    logic signed [15:0]    change_amt;
    logic signed [SUM_W-1:0] sp_sum;
    logic signed [SUM_W-1:0] sp_max, sp_min;
    logic [8:0]            sp_clamped;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_on_mode_reg    <= POWER_ON_RST;
            sleep_minutes_reg    <= SLEEP_MIN_RST;
            standby_minutes_reg  <= STANDBY_MIN_RST;
            temp_step_size_reg   <= STEP_RST;
            setpoint_hold_ms_reg <= HOLD_MS_RST;
            temp_min_reg         <= TEMP_MIN_RST;
            temp_max_reg         <= TEMP_MAX_RST;
            initial_setpoint_reg <= INIT_SP_RST;
            sleep_limit_reg      <= LIMIT_W'(32'(SLEEP_MIN_RST) * MS_PER_MINUTE);
            standby_limit_reg    <= LIMIT_W'(32'(STANDBY_MIN_RST) * MS_PER_MINUTE);
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_POWER_ON_MODE:    power_on_mode_reg <= pwdata[1:0];
                REG_SLEEP_MINUTES:
                begin
                    sleep_minutes_reg <= pwdata[7:0];
                    sleep_limit_reg   <= LIMIT_W'(32'(pwdata[7:0]) * MS_PER_MINUTE);
                end
                REG_STANDBY_MINUTES:
                begin
                    standby_minutes_reg <= pwdata[7:0];
                    standby_limit_reg   <= LIMIT_W'(32'(pwdata[7:0]) * MS_PER_MINUTE);
                end
                REG_TEMP_STEP_SIZE:   temp_step_size_reg   <= pwdata[6:0];
                REG_SETPOINT_HOLD_MS: setpoint_hold_ms_reg <= pwdata[15:0];
                REG_TEMP_MIN:         temp_min_reg         <= pwdata[8:0];
                REG_TEMP_MAX:         temp_max_reg         <= pwdata[8:0];
                REG_INITIAL_SETPOINT: initial_setpoint_reg <= pwdata[8:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_POWER_ON_MODE:    prdata = 32'(power_on_mode_reg);
            REG_SLEEP_MINUTES:    prdata = 32'(sleep_minutes_reg);
            REG_STANDBY_MINUTES:  prdata = 32'(standby_minutes_reg);
            REG_TEMP_STEP_SIZE:   prdata = 32'(temp_step_size_reg);
            REG_SETPOINT_HOLD_MS: prdata = 32'(setpoint_hold_ms_reg);
            REG_TEMP_MIN:         prdata = 32'(temp_min_reg);
            REG_TEMP_MAX:         prdata = 32'(temp_max_reg);
            REG_INITIAL_SETPOINT: prdata = 32'(initial_setpoint_reg);
        endcase
    end

    // ------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            now_reg   <= TIME_BITS'(now_ms);
            delta_reg <= encoder_delta;
            held_reg  <= button_held;
            click_reg <= short_click;
            long_reg  <= long_click;
            moved_reg <= motion_seen;
        end
    end

    // ------------------------------------------------------------------
    // Poll decode
    // ------------------------------------------------------------------
    assign delta_nz  = (delta_reg != 8'sd0);
    assign idle_ms   = now_reg - active_time_reg;
    assign knob_ms   = now_reg - knob_time_reg;
    assign change_ms = now_reg - change_time_reg;

    assign sleep_due   = CMP_W'(idle_ms) > CMP_W'(sleep_limit_reg);
    assign standby_due = CMP_W'(idle_ms) > CMP_W'(standby_limit_reg);
    assign save_due    = change_pending_reg && (CMP_W'(change_ms) > CMP_W'(SAVE_DELAY_MS));
    assign hold_done   = (CMP_W'(knob_ms) > CMP_W'(setpoint_hold_ms_reg)) && !held_reg;

    // The step product spans at most 15 bits; the sum with the setpoint fits SUM_W.
    assign step_product = 16'(delta_reg * $signed({1'b0, temp_step_size_reg}));
    assign change_amt   = held_reg ? 16'(delta_reg) : step_product;
    assign sp_sum       = $signed({{(SUM_W-9){1'b0}}, setpoint_reg})
                          + $signed({{(SUM_W-16){change_amt[15]}}, change_amt});
    assign sp_max       = $signed({{(SUM_W-9){1'b0}}, temp_max_reg});
    assign sp_min       = $signed({{(SUM_W-9){1'b0}}, temp_min_reg});

    // When the bounds are crossed, the upper bound wins for a sum above it, else the lower bound.
    always_comb
    begin
        priority if (sp_sum > sp_max)
        begin
            sp_clamped = temp_max_reg;
        end
        else if (sp_sum < sp_min)
        begin
            sp_clamped = temp_min_reg;
        end
        else
        begin
            sp_clamped = sp_sum[8:0];
        end
    end

    assign adjust = (mode_reg == MODE_SETPT) && delta_nz;

    // Next mode
    always_comb
    begin
        mode_next = mode_reg;
        unique case (mode_reg)
            MODE_INIT:
            begin
                if (!held_reg)
                begin
                    unique case (pon_mode_t'(power_on_mode_reg))
                        PON_STANDBY:          mode_next = MODE_STANDBY;
                        PON_SLEEP:            mode_next = MODE_SLEEP;
                        PON_RUN, PON_ALT_RUN: mode_next = MODE_RUN;
                    endcase
                end
            end
            MODE_SETPT:
            begin
                if (!delta_nz && hold_done)
                begin
                    mode_next = MODE_RUN;
                end
            end
            MODE_RUN, MODE_BOOST, MODE_STANDBY, MODE_SLEEP:
            begin
                priority if (delta_nz)
                begin
                    mode_next = MODE_SETPT;
                end
                else if (click_reg)
                begin
                    unique case (mode_reg)
                        MODE_RUN:     mode_next = MODE_BOOST;
                        MODE_BOOST:   mode_next = MODE_STANDBY;
                        MODE_STANDBY: mode_next = MODE_SLEEP;
                        default:      mode_next = MODE_RUN;
                    endcase
                end
                else if (long_reg)
                begin
                    mode_next = mode_reg;
                end
                else if (moved_reg)
                begin
                    mode_next = MODE_RUN;
                end
                else if (mode_reg != MODE_SLEEP && sleep_due)
                begin
                    mode_next = MODE_SLEEP;
                end
                else if ((mode_reg == MODE_RUN || mode_reg == MODE_BOOST) && standby_due)
                begin
                    mode_next = MODE_STANDBY;
                end
                else
                begin
                    mode_next = mode_reg;
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    // Timers, setpoint and pulses
    always_comb
    begin
        active_time_next    = active_time_reg;
        knob_time_next      = delta_nz ? now_reg : knob_time_reg;
        setpoint_next       = adjust ? sp_clamped : setpoint_reg;
        change_time_next    = adjust ? now_reg : change_time_reg;
        change_pending_next = adjust || (change_pending_reg && !save_due);
        save_next           = save_due;
        menu_next           = 1'b0;
        unique case (mode_reg)
            MODE_SETPT:
            begin
                if (delta_nz || (!hold_done && moved_reg))
                begin
                    active_time_next = now_reg;
                end
            end
            MODE_RUN, MODE_BOOST, MODE_STANDBY, MODE_SLEEP:
            begin
                if (delta_nz || click_reg || long_reg || moved_reg)
                begin
                    active_time_next = now_reg;
                end
                menu_next = !delta_nz && !click_reg && long_reg;
            end
            default:
            begin
                active_time_next = active_time_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= MODE_INIT;
            setpoint_reg       <= INIT_SP_RST;
            active_time_reg    <= '0;
            knob_time_reg      <= '0;
            change_pending_reg <= 1'b0;
            change_time_reg    <= '0;
        end
        else if (advance)
        begin
            mode_reg           <= mode_next;
            setpoint_reg       <= setpoint_next;
            active_time_reg    <= active_time_next;
            knob_time_reg      <= knob_time_next;
            change_pending_reg <= change_pending_next;
            change_time_reg    <= change_time_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mode_out_reg     <= mode_next;
            setpoint_out_reg <= setpoint_next;
            save_reg         <= save_next;
            menu_reg         <= menu_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign mode           = mode_out_reg;
    assign setpoint_value = setpoint_out_reg;
    assign save_pulse     = save_reg;
    assign menu_request   = menu_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_PROP(a_sp_only_in_setpt, clk, rst_n, (advance && setpoint_next != setpoint_reg) |-> (mode_reg == MODE_SETPT))
    `ASSERT_PROP(a_menu_keeps_mode, clk, rst_n, (advance && menu_next) |-> (mode_next == mode_reg))
    `ASSERT_PROP(a_stall_only_full, clk, rst_n, !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
    `ASSERT_PROP(a_pending_cleared_by_save, clk, rst_n, $fell(change_pending_reg) |-> $past(advance && save_next))
    `ASSERT_NEVER(a_save_and_adjust, clk, rst_n, advance && save_next && change_pending_next && !adjust)

endmodule

// ===== bench/iron_mode_controller_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iron_mode_controller_unit_tb
// Self-checking bench for the iron mode controller. Poll requests are queued
// by a stimulus thread, driven with random gaps and checked against a bench
// model of the mode, setpoint, timeout, save and menu behavior, over several
// register settings written between phases.
// ----------------------------------------------------------------------------
module iron_mode_controller_unit_tb;
    import imc_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic [31:0]       now;
        logic signed [7:0] delta;
        logic              held;
        logic              click;
        logic              lng;
        logic              moved;
    } poll_t;

    typedef struct {
        mode_t      md;
        logic [8:0] sp;
        logic       save;
        logic       menu;
    } status_t;

    typedef struct {
        pon_mode_t   pon;
        logic [7:0]  sleep_min;
        logic [7:0]  standby_min;
        logic [6:0]  step;
        logic [15:0] hold;
        logic [8:0]  tmin;
        logic [8:0]  tmax;
        logic [8:0]  init_sp;
    } settings_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [31:0]         now_ms = '0;
    logic signed [7:0]   encoder_delta = '0;
    logic                button_held = 1'b0;
    logic                short_click = 1'b0;
    logic                long_click = 1'b0;
    logic                motion_seen = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [2:0]          mode;
    logic [8:0]          setpoint_value;
    logic                save_pulse;
    logic                menu_request;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    iron_mode_controller_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .now_ms         (now_ms),
        .encoder_delta  (encoder_delta),
        .button_held    (button_held),
        .short_click    (short_click),
        .long_click     (long_click),
        .motion_seen    (motion_seen),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .mode           (mode),
        .setpoint_value (setpoint_value),
        .save_pulse     (save_pulse),
        .menu_request   (menu_request),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #6 clk = ~clk;

    // Bench copy of the controller state and its register settings.
    settings_t   cfg;
    mode_t       ctl_mode;
    logic [8:0]  ctl_setpoint;
    logic [31:0] last_active_ms;
    logic [31:0] last_knob_ms;
    logic [31:0] last_change_ms;
    logic        save_owed;

    poll_t   poll_q[$];
    status_t predicted_status_q[$];
    poll_t   cur_poll;

    int unsigned polls_queued = 0;
    int unsigned polls_accepted = 0;
    int unsigned results_seen = 0;
    int unsigned fail_count = 0;
    int unsigned save_count = 0;
    int unsigned menu_count = 0;
    int unsigned settings_used = 0;
    bit [5:0]    modes_seen = '0;

    int unsigned gap_left = 0;
    int unsigned calm_polls = 0;
    int unsigned drive_pick;
    int unsigned calm_cycles = 0;
    int unsigned stall_left = 0;
    int unsigned squeeze_left = 0;
    bit          squeeze_done = 1'b0;
    int unsigned ready_pick;
    logic [31:0] t_now = '0;

    function automatic status_t advance_controller(input poll_t p);
        status_t     r;
        logic [31:0] idle_ms;
        bit          sleep_due;
        bit          standby_due;
        int          change;
        int          v;
        idle_ms     = p.now - last_active_ms;
        sleep_due   = longint'(idle_ms) > longint'(cfg.sleep_min) * MS_PER_MINUTE;
        standby_due = longint'(idle_ms) > longint'(cfg.standby_min) * MS_PER_MINUTE;
        r.save = 1'b0;
        r.menu = 1'b0;

        if (p.delta != 0)
            last_knob_ms = p.now;
        if (save_owed && (p.now - last_change_ms) > SAVE_DELAY_MS) begin
            r.save = 1'b1;
            save_owed = 1'b0;
        end

        case (ctl_mode)
            MODE_INIT: begin
                if (!p.held) begin
                    if (cfg.pon == PON_STANDBY)
                        ctl_mode = MODE_STANDBY;
                    else if (cfg.pon == PON_SLEEP)
                        ctl_mode = MODE_SLEEP;
                    else
                        ctl_mode = MODE_RUN;
                end
            end
            MODE_SETPT: begin
                if (p.delta != 0) begin
                    last_active_ms = p.now;
                    change = p.held ? int'(p.delta) : int'(p.delta) * int'(cfg.step);
                    v = int'(ctl_setpoint) + change;
                    // When min is set above max, the upper bound wins for a sum above it, else the lower bound.
                    if (v > int'(cfg.tmax))
                        v = int'(cfg.tmax);
                    else if (v < int'(cfg.tmin))
                        v = int'(cfg.tmin);
                    ctl_setpoint   = v[8:0];
                    save_owed      = 1'b1;
                    last_change_ms = p.now;
                end
                else if ((p.now - last_knob_ms) > cfg.hold && !p.held) begin
                    ctl_mode = MODE_RUN;
                end
                else if (p.moved) begin
                    last_active_ms = p.now;
                end
            end
            MODE_RUN, MODE_BOOST, MODE_STANDBY, MODE_SLEEP: begin
                if (p.delta != 0) begin
                    last_active_ms = p.now;
                    ctl_mode = MODE_SETPT;
                end
                else if (p.click) begin
                    last_active_ms = p.now;
                    case (ctl_mode)
                        MODE_RUN:     ctl_mode = MODE_BOOST;
                        MODE_BOOST:   ctl_mode = MODE_STANDBY;
                        MODE_STANDBY: ctl_mode = MODE_SLEEP;
                        default:      ctl_mode = MODE_RUN;
                    endcase
                end
                else if (p.lng) begin
                    last_active_ms = p.now;
                    r.menu = 1'b1;
                end
                else if (p.moved) begin
                    last_active_ms = p.now;
                    ctl_mode = MODE_RUN;
                end
                else if (ctl_mode != MODE_SLEEP && sleep_due) begin
                    ctl_mode = MODE_SLEEP;
                end
                else if ((ctl_mode == MODE_RUN || ctl_mode == MODE_BOOST) && standby_due) begin
                    ctl_mode = MODE_STANDBY;
                end
            end
            default: begin
            end
        endcase

        r.md = ctl_mode;
        r.sp = ctl_setpoint;
        return r;
    endfunction

    // Poll request driver.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else begin
            if (in_valid && in_ready) begin
                predicted_status_q.push_back(advance_controller(cur_poll));
                polls_accepted++;
            end
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (poll_q.size() > 0) begin
                    cur_poll = poll_q.pop_front();
                    now_ms        <= cur_poll.now;
                    encoder_delta <= cur_poll.delta;
                    button_held   <= cur_poll.held;
                    short_click   <= cur_poll.click;
                    long_click    <= cur_poll.lng;
                    motion_seen   <= cur_poll.moved;
                    in_valid      <= 1'b1;
                    if (calm_polls > 0) begin
                        calm_polls--;
                    end
                    else begin
                        drive_pick = $urandom_range(0, 99);
                        if (drive_pick < 5)
                            calm_polls = $urandom_range(20, 60);
                        else if (drive_pick >= 88)
                            gap_left = $urandom_range(6, 40);
                        else if (drive_pick >= 55)
                            gap_left = $urandom_range(1, 3);
                    end
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result side ready, with one long hold-off once the run is under way.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else if (squeeze_left > 0) begin
            squeeze_left--;
            out_ready <= 1'b0;
        end
        else if (!squeeze_done && polls_accepted >= 150) begin
            squeeze_done = 1'b1;
            squeeze_left = 150;
            out_ready <= 1'b0;
        end
        else if (calm_cycles > 0) begin
            calm_cycles--;
            out_ready <= 1'b1;
        end
        else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else begin
            ready_pick = $urandom_range(0, 99);
            if (ready_pick < 8) begin
                calm_cycles = $urandom_range(30, 80);
                out_ready <= 1'b1;
            end
            else if (ready_pick < 60) begin
                out_ready <= 1'b1;
            end
            else if (ready_pick < 92) begin
                stall_left = $urandom_range(0, 2);
                out_ready <= 1'b0;
            end
            else begin
                stall_left = $urandom_range(5, 40);
                out_ready <= 1'b0;
            end
        end
    end

    // Result checker.
    always @(posedge clk) begin
        status_t want;
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (mode <= 3'd5)
                modes_seen[mode] = 1'b1;
            if (predicted_status_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("ERROR: result with no poll outstanding: mode %0d setpoint %0d",
                             mode, setpoint_value);
            end
            else begin
                want = predicted_status_q.pop_front();
                if (want.save)
                    save_count++;
                if (want.menu)
                    menu_count++;
                if (mode !== want.md || setpoint_value !== want.sp
                        || save_pulse !== want.save || menu_request !== want.menu) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ERROR: result %0d: expected mode %0d sp %0d save %0d menu %0d, got mode %0d sp %0d save %0d menu %0d",
                                 results_seen, want.md, want.sp, want.save, want.menu,
                                 mode, setpoint_value, save_pulse, menu_request);
                end
            end
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_settings(input settings_t s);
        write_reg(REG_POWER_ON_MODE,    32'(s.pon));
        write_reg(REG_SLEEP_MINUTES,    32'(s.sleep_min));
        write_reg(REG_STANDBY_MINUTES,  32'(s.standby_min));
        write_reg(REG_TEMP_STEP_SIZE,   32'(s.step));
        write_reg(REG_SETPOINT_HOLD_MS, 32'(s.hold));
        write_reg(REG_TEMP_MIN,         32'(s.tmin));
        write_reg(REG_TEMP_MAX,         32'(s.tmax));
        write_reg(REG_INITIAL_SETPOINT, 32'(s.init_sp));
        cfg = s;
        settings_used++;
    endtask

    task automatic wait_idle();
        while (results_seen != polls_queued)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic queue_poll(input logic [31:0] now, input logic signed [7:0] delta,
                              input logic held, input logic click,
                              input logic lng, input logic moved);
        poll_t p;
        p.now   = now;
        p.delta = delta;
        p.held  = held;
        p.click = click;
        p.lng   = lng;
        p.moved = moved;
        poll_q.push_back(p);
        polls_queued++;
        t_now = now;
    endtask

    task automatic queue_random_polls(input int unsigned count);
        int unsigned       pick;
        logic signed [7:0] delta;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            // Mostly small time steps; some reach the save delay, some the
            // idle timeouts, and a few land anywhere on the clock.
            if (pick < 70)
                t_now = t_now + $urandom_range(0, 1500);
            else if (pick < 88)
                t_now = t_now + $urandom_range(1000, 40000);
            else if (pick < 97)
                t_now = t_now + $urandom_range(60000, 16000000);
            else
                t_now = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 45)
                delta = 8'sd0;
            else if (pick < 85)
                delta = $urandom_range(0, 1) ? 8'sd0 - 8'($urandom_range(1, 4))
                                             : 8'($urandom_range(1, 4));
            else
                delta = 8'($urandom);
            queue_poll(t_now, delta, $urandom_range(0, 99) < 15, $urandom_range(0, 99) < 12,
                       $urandom_range(0, 99) < 8, $urandom_range(0, 99) < 15);
        end
    endtask

    initial begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("iron_mode_controller_unit regression: fail");
        $finish;
    end

    initial begin
        settings_t s;
        cfg.pon         = pon_mode_t'(POWER_ON_RST);
        cfg.sleep_min   = SLEEP_MIN_RST;
        cfg.standby_min = STANDBY_MIN_RST;
        cfg.step        = STEP_RST;
        cfg.hold        = HOLD_MS_RST;
        cfg.tmin        = TEMP_MIN_RST;
        cfg.tmax        = TEMP_MAX_RST;
        cfg.init_sp     = INIT_SP_RST;
        ctl_mode        = MODE_INIT;
        ctl_setpoint    = INIT_SP_RST;
        last_active_ms  = '0;
        last_knob_ms    = '0;
        last_change_ms  = '0;
        save_owed       = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Power-on code 3 only shows while the block is still in init.
        write_reg(REG_POWER_ON_MODE, 32'(PON_ALT_RUN));
        cfg.pon = PON_ALT_RUN;

        // Directed: init held, click ring, long press, clamps, hold expiry,
        // strict save and idle limits, and time wrapping past zero.
        queue_poll(32'd1000, 8'sd5, 1, 1, 0, 0);
        queue_poll(32'd1010, 8'sd0, 0, 0, 0, 0);
        queue_poll(32'd1020, 8'sd0, 0, 1, 0, 0);
        queue_poll(32'd1030, 8'sd0, 0, 1, 0, 0);
        queue_poll(32'd1040, 8'sd0, 0, 1, 0, 0);
        queue_poll(32'd1050, 8'sd0, 0, 1, 0, 0);
        queue_poll(32'd1060, 8'sd0, 0, 0, 1, 0);
        queue_poll(32'd1070, 8'sd127, 0, 0, 0, 0);
        queue_poll(32'd1080, 8'sd127, 0, 0, 0, 0);
        queue_poll(32'd1090, -8'sd128, 0, 0, 0, 0);
        queue_poll(32'd1100, 8'sd1, 1, 0, 0, 0);
        queue_poll(32'd1200, 8'sd0, 0, 0, 0, 1);
        queue_poll(32'd2100, 8'sd0, 0, 0, 0, 0);
        queue_poll(32'd2101, 8'sd0, 0, 0, 0, 0);
        queue_poll(32'd31100, 8'sd0, 0, 0, 0, 0);
        queue_poll(32'd31101, 8'sd0, 0, 0, 0, 0);
        queue_poll(32'd40000, 8'sd0, 0, 0, 0, 1);
        queue_poll(32'd340000, 8'sd0, 0, 0, 0, 0);
        queue_poll(32'd340001, 8'sd0, 0, 0, 0, 0);
        queue_poll(32'd350000, 8'sd0, 0, 0, 0, 1);
        queue_poll(32'd2150000, 8'sd0, 0, 0, 0, 0);
        queue_poll(32'd2150001, 8'sd0, 0, 0, 0, 0);
        queue_poll(32'hFFFF_FFF0, 8'sd0, 0, 0, 0, 1);
        queue_poll(32'hFFFF_FFFF, 8'sd0, 0, 0, 0, 0);
        queue_poll(32'h0000_0010, 8'sd0, 0, 0, 0, 0);
        queue_random_polls(250);

        // Low extremes: zero timeouts and hold, unit step, full setpoint range.
        wait_idle();
        s.pon = PON_SLEEP; s.sleep_min = 8'd0; s.standby_min = 8'd0; s.step = 7'd1;
        s.hold = 16'd0; s.tmin = 9'd0; s.tmax = 9'd511; s.init_sp = 9'd511;
        apply_settings(s);
        queue_random_polls(200);

        // High extremes, with the minimum set above the maximum.
        wait_idle();
        s.pon = PON_STANDBY; s.sleep_min = 8'd255; s.standby_min = 8'd255; s.step = 7'd100;
        s.hold = 16'd65535; s.tmin = 9'd400; s.tmax = 9'd200; s.init_sp = 9'd0;
        apply_settings(s);
        queue_random_polls(200);

        repeat (2) begin
            wait_idle();
            s.pon         = pon_mode_t'($urandom_range(0, 3));
            s.sleep_min   = $urandom_range(0, 40);
            s.standby_min = $urandom_range(0, 10);
            s.step        = $urandom_range(1, 100);
            s.hold        = $urandom_range(0, 3000);
            s.tmin        = $urandom_range(0, 511);
            s.tmax        = $urandom_range(0, 511);
            s.init_sp     = $urandom_range(0, 511);
            apply_settings(s);
            queue_random_polls(125);
        end

        while (results_seen != polls_queued)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (predicted_status_q.size() != 0)
            fail_count++;

        $display("Covered %0d polls under %0d register settings; %0d results checked.",
                 polls_accepted, settings_used + 1, results_seen);
        $display("Modes reached (bit per mode): %b, save pulses %0d, menu requests %0d.",
                 modes_seen, save_count, menu_count);
        if (fail_count == 0)
            $display("iron_mode_controller_unit regression: pass");
        else
            $display("iron_mode_controller_unit regression: fail");
        $finish;
    end

endmodule
